// ===== hw/rtl/gdpt_pkg.sv =====
// Shared types and constants for the grid distance path tracer.
// Holds the request and result structures, kind and register codes, and label codes.
// No dependencies.
package gdpt_pkg;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_RUN   = 2'd2,
        KIND_MARK  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [4:0]         pos_row;
        logic [4:0]         pos_col;
        logic [4:0]         exit_row;
        logic [4:0]         exit_col;
        logic signed [15:0] cell_value;
    } t_item;

    typedef struct packed {
        logic signed [15:0] read_value;
        logic [10:0]        path_length;
        logic [14:0]        max_distance;
        logic               status;
    } t_result;

    localparam logic CFG_NUM_ROWS = 1'b0;
    localparam logic CFG_NUM_COLS = 1'b1;
    localparam logic [5:0] CFG_DIM_RESET = 6'd32;

    localparam int LBL_PATH = -6;
    localparam int LBL_EXIT = -5;
    localparam int LBL_DEAD = -1;
    localparam int LBL_MARK = -4;
    localparam int MAX_DIST = 32767;

endpackage

// ===== hw/rtl/gdpt_grid_ram.sv =====
// Synchronous label memory of the path tracer: one write port, one read port.
// Read data is registered and appears in the cycle after the request.
// No dependencies.
module gdpt_grid_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/gdpt_seq.sv =====
// Sequencer of the path tracer: cell access, area sweeps, search walk and marking walk.
// Drives the label memory through read-modify-write steps. Depends on gdpt_pkg.
module gdpt_seq import gdpt_pkg::*; #(
    parameter int MAX_ROWS   = 32,
    parameter int MAX_COLS   = 32,
    parameter int LABEL_BITS = 16,
    parameter int AW         = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_item_valid,
    output logic                  o_item_ready,
    input  t_item                 i_item,
    input  logic [5:0]            i_used_rows,
    input  logic [5:0]            i_used_cols,
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output t_result               o_res,
    output logic                  o_ram_we,
    output logic [AW-1:0]         o_ram_waddr,
    output logic [LABEL_BITS-1:0] o_ram_wdata,
    output logic                  o_ram_re,
    output logic [AW-1:0]         o_ram_raddr,
    input  logic [LABEL_BITS-1:0] i_ram_rdata
);

    localparam int LB = LABEL_BITS;
    localparam logic [1:0] DIR_DOWN  = 2'd0;
    localparam logic [1:0] DIR_LEFT  = 2'd1;
    localparam logic [1:0] DIR_UP    = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;
    localparam logic signed [LB-1:0] L_PATH = LB'(LBL_PATH);
    localparam logic signed [LB-1:0] L_EXIT = LB'(LBL_EXIT);
    localparam logic signed [LB-1:0] L_DEAD = LB'(LBL_DEAD);
    localparam logic signed [LB-1:0] L_MARK = LB'(LBL_MARK);

    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_RDWAIT = 12'b000000000010,
        S_MARK   = 12'b000000000100,
        S_MAXSW  = 12'b000000001000,
        S_DECIDE = 12'b000000010000,
        S_STEP   = 12'b000000100000,
        S_CURWT  = 12'b000001000000,
        S_PROBE  = 12'b000010000000,
        S_CHECK  = 12'b000100000000,
        S_AFTER  = 12'b001000000000,
        S_EXITWR = 12'b010000000000,
        S_DONE   = 12'b100000000000
    } t_state;

    function automatic logic [AW-1:0] cell_addr(input logic [5:0] row, input logic [5:0] col);
        cell_addr = AW'(int'(row) * MAX_COLS + int'(col));
    endfunction

    t_state r_state, n_state;
    t_item  r_item, n_item;
    t_result r_res, n_res;
    logic [5:0] r_sr, n_sr, r_sc, n_sc;
    logic r_sw_issue, n_sw_issue, r_pv, n_pv;
    logic [AW-1:0] r_paddr, n_paddr;
    logic signed [LB-1:0] r_best, n_best, r_cur, n_cur;
    logic [14:0] r_biggest, n_biggest;
    logic [11:0] r_limit, n_limit, r_i, n_i, r_j, n_j;
    logic [5:0] r_cr, n_cr, r_cc, n_cc, r_or, n_or, r_oc, n_oc, r_pr, n_pr, r_pc, n_pc;
    logic [1:0] r_dir, n_dir;
    logic r_moved, n_moved, r_marking, n_marking, r_have_prev, n_have_prev;

    logic signed [LB-1:0] rdata_s;
    logic signed [32:0] want;
    logic [5:0] er, ec, xr, xc, nb_r, nb_c;
    logic nb_ok, at_exit, in_store;
    logic [11:0] i_nx, j_nx;
    logic [14:0] sat_best;

    assign rdata_s = signed'(i_ram_rdata);
    assign want    = 33'(r_cur) + 33'sd1;
    assign er      = {1'b0, r_item.pos_row};
    assign ec      = {1'b0, r_item.pos_col};
    assign xr      = {1'b0, r_item.exit_row};
    assign xc      = {1'b0, r_item.exit_col};
    assign at_exit = (r_cr == xr) && (r_cc == xc);
    assign i_nx    = r_i + 12'd1;
    assign j_nx    = r_j + 12'd1;
    assign in_store = ({4'b0, i_item.pos_row} < 9'(MAX_ROWS))
                   && ({4'b0, i_item.pos_col} < 9'(MAX_COLS));
    assign sat_best = (33'($unsigned(r_best)) > 33'(MAX_DIST)) ? 15'(MAX_DIST)
                                                                : 15'(r_best);

    always_comb begin
        nb_r  = r_cr;
        nb_c  = r_cc;
        nb_ok = 1'b0;
        case (r_dir)
            DIR_DOWN: begin
                nb_r  = r_cr + 6'd1;
                nb_ok = ({1'b0, r_cr} + 7'd1) < {1'b0, i_used_rows};
            end
            DIR_LEFT: begin
                nb_c  = r_cc - 6'd1;
                nb_ok = (r_cc != 6'd0);
            end
            DIR_UP: begin
                nb_r  = r_cr - 6'd1;
                nb_ok = (r_cr != 6'd0);
            end
            default: begin
                nb_c  = r_cc + 6'd1;
                nb_ok = ({1'b0, r_cc} + 7'd1) < {1'b0, i_used_cols};
            end
        endcase
    end

    always_comb begin
        n_state = r_state; n_item = r_item; n_res = r_res;
        n_sr = r_sr; n_sc = r_sc; n_sw_issue = r_sw_issue; n_pv = 1'b0; n_paddr = r_paddr;
        n_best = r_best; n_cur = r_cur; n_biggest = r_biggest;
        n_limit = r_limit; n_i = r_i; n_j = r_j;
        n_cr = r_cr; n_cc = r_cc; n_or = r_or; n_oc = r_oc; n_pr = r_pr; n_pc = r_pc;
        n_dir = r_dir; n_moved = r_moved; n_marking = r_marking; n_have_prev = r_have_prev;
        o_ram_we = 1'b0; o_ram_waddr = '0; o_ram_wdata = '0;
        o_ram_re = 1'b0; o_ram_raddr = '0;
        o_item_ready = (r_state == S_IDLE);
        o_res_valid  = (r_state == S_DONE);

        unique case (r_state)
            S_IDLE: begin
                if (i_item_valid) begin
                    n_item = i_item;
                    n_res  = '0;
                    n_sr = 6'd0; n_sc = 6'd0;
                    n_sw_issue = (i_used_rows != 6'd0) && (i_used_cols != 6'd0);
                    n_best = '0;
                    unique case (i_item.kind)
                        KIND_WRITE: begin
                            o_ram_we    = in_store;
                            o_ram_waddr = cell_addr({1'b0, i_item.pos_row},
                                                    {1'b0, i_item.pos_col});
                            o_ram_wdata = LB'(32'(i_item.cell_value));
                            n_state     = S_DONE;
                        end
                        KIND_READ: begin
                            o_ram_re    = in_store;
                            o_ram_raddr = cell_addr({1'b0, i_item.pos_row},
                                                    {1'b0, i_item.pos_col});
                            n_state     = in_store ? S_RDWAIT : S_DONE;
                        end
                        KIND_MARK: n_state = S_MARK;
                        default:   n_state = S_MAXSW;
                    endcase
                end
            end
            S_RDWAIT: begin
                n_res.read_value = 16'(32'(rdata_s));
                n_state = S_DONE;
            end
            S_MARK, S_MAXSW: begin
                if (r_sw_issue) begin
                    o_ram_re    = 1'b1;
                    o_ram_raddr = cell_addr(r_sr, r_sc);
                    n_pv        = 1'b1;
                    n_paddr     = o_ram_raddr;
                    if (({1'b0, r_sc} + 7'd1) < {1'b0, i_used_cols}) begin
                        n_sc = r_sc + 6'd1;
                    end else begin
                        n_sc = 6'd0;
                        if (({1'b0, r_sr} + 7'd1) < {1'b0, i_used_rows}) begin
                            n_sr = r_sr + 6'd1;
                        end else begin
                            n_sw_issue = 1'b0;
                        end
                    end
                end
                if (r_pv) begin
                    if (r_state == S_MARK) begin
                        o_ram_we    = (32'(rdata_s) == 32'(r_item.cell_value));
                        o_ram_waddr = r_paddr;
                        o_ram_wdata = L_MARK;
                    end else if (rdata_s > r_best) begin
                        n_best = rdata_s;
                    end
                end
                if (!r_sw_issue && !r_pv) begin
                    n_state = (r_state == S_MARK) ? S_DONE : S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_biggest = sat_best;
                n_res.max_distance = sat_best;
                if (er >= i_used_rows || ec >= i_used_cols
                        || xr >= i_used_rows || xc >= i_used_cols) begin
                    n_res.status = 1'b1;
                    n_state = S_DONE;
                end else if (er == xr && ec == xc) begin
                    o_ram_we    = 1'b1;
                    o_ram_waddr = cell_addr(er, ec);
                    o_ram_wdata = L_PATH;
                    n_state     = S_DONE;
                end else begin
                    n_limit = 12'({6'b0, i_used_rows}) * 12'({6'b0, i_used_cols});
                    n_i = '0; n_j = '0; n_marking = 1'b0;
                    n_cr = er; n_cc = ec;
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                o_ram_re    = 1'b1;
                o_ram_raddr = cell_addr(r_cr, r_cc);
                n_state     = S_CURWT;
            end
            S_CURWT: begin
                n_cur   = rdata_s;
                n_dir   = DIR_DOWN;
                n_state = S_PROBE;
            end
            S_PROBE: begin
                if (nb_ok) begin
                    o_ram_re    = 1'b1;
                    o_ram_raddr = cell_addr(nb_r, nb_c);
                    n_state     = S_CHECK;
                end else if (r_dir == DIR_RIGHT) begin
                    n_moved = 1'b0;
                    n_state = S_AFTER;
                end else begin
                    n_dir = r_dir + 2'd1;
                end
            end
            S_CHECK: begin
                if (33'(rdata_s) == want) begin
                    n_or = r_cr; n_oc = r_cc;
                    n_cr = nb_r; n_cc = nb_c;
                    n_moved = 1'b1;
                    n_state = S_AFTER;
                end else if (r_dir == DIR_RIGHT) begin
                    n_moved = 1'b0;
                    n_state = S_AFTER;
                end else begin
                    n_dir   = r_dir + 2'd1;
                    n_state = S_PROBE;
                end
            end
            S_AFTER: begin
                if (!r_marking) begin
                    if (r_moved && at_exit) begin
                        n_marking = 1'b1; n_have_prev = 1'b0;
                        n_pr = 6'd0; n_pc = 6'd0;
                        n_i = '0; n_j = '0; n_cr = er; n_cc = ec;
                        n_state = S_STEP;
                    end else if (r_moved && j_nx < r_limit) begin
                        n_j = j_nx;
                        n_state = S_STEP;
                    end else begin
                        if (!r_moved) begin
                            o_ram_we    = 1'b1;
                            o_ram_waddr = cell_addr(r_cr, r_cc);
                            o_ram_wdata = L_DEAD;
                        end
                        if (i_nx < r_limit) begin
                            n_i = i_nx; n_j = '0; n_cr = er; n_cc = ec;
                            n_state = S_STEP;
                        end else begin
                            n_res.status = 1'b1;
                            n_state = S_DONE;
                        end
                    end
                end else begin
                    if (r_moved) begin
                        n_pr = r_or; n_pc = r_oc; n_have_prev = 1'b1;
                    end
                    o_ram_we    = r_moved || r_have_prev;
                    o_ram_waddr = r_moved ? cell_addr(r_or, r_oc) : cell_addr(r_pr, r_pc);
                    o_ram_wdata = L_PATH;
                    if (at_exit) begin
                        n_state = S_EXITWR;
                    end else if (j_nx < r_limit) begin
                        n_j = j_nx;
                        n_state = S_STEP;
                    end else if (i_nx < r_limit) begin
                        n_i = i_nx; n_j = '0; n_cr = er; n_cc = ec;
                        n_state = S_STEP;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_EXITWR: begin
                o_ram_we    = 1'b1;
                o_ram_waddr = cell_addr(xr, xc);
                o_ram_wdata = ({3'b0, j_nx} == r_biggest) ? L_EXIT : L_PATH;
                n_res.path_length = 11'(j_nx);
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_sw_issue <= 1'b0;
            r_pv       <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_sw_issue <= n_sw_issue;
            r_pv       <= n_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item; r_res <= n_res;
        r_sr <= n_sr; r_sc <= n_sc; r_paddr <= n_paddr;
        r_best <= n_best; r_cur <= n_cur; r_biggest <= n_biggest;
        r_limit <= n_limit; r_i <= n_i; r_j <= n_j;
        r_cr <= n_cr; r_cc <= n_cc; r_or <= n_or; r_oc <= n_oc; r_pr <= n_pr; r_pc <= n_pc;
        r_dir <= n_dir; r_moved <= n_moved; r_marking <= n_marking;
        r_have_prev <= n_have_prev;
    end

    assign o_res = r_res;

`ifndef ASSERT_OFF
    a_no_same_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ram_we && o_ram_re) |-> (o_ram_waddr != o_ram_raddr))
        else $error("Write and read of the same cell in one cycle.");
    a_res_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !i_res_ready) |=> (o_res_valid && $stable(o_res)))
        else $error("Pending result dropped or changed.");
    a_walk_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP) |-> ((r_j < r_limit) && (r_i < r_limit)))
        else $error("Walk counter beyond its budget.");
    a_check_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> $past(o_ram_re))
        else $error("Neighbour compared without a read.");
`endif

endmodule

// ===== hw/rtl/grid_distance_path_tracer_top.sv =====
// Grid distance path tracer: serves write, read, mark and run requests on a label memory.
// A mark request sweeps the used area; a run sweeps it for the largest label, decides, and may
// walk, each step reading the current cell and probing neighbours on the grid in turn; a marking
// walk ends in the exit write. One request runs at a time; the next waits until it is done.
// Reset clears the output valid flag, returns to idle and sets both dimensions to 32;
// grid labels are undefined until written. Depends on gdpt_pkg, gdpt_seq and gdpt_grid_ram.
module grid_distance_path_tracer_top import gdpt_pkg::*; #(
    parameter int MAX_ROWS   = 32,
    parameter int MAX_COLS   = 32,
    parameter int LABEL_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_kind,
    input  logic [4:0]         i_pos_row,
    input  logic [4:0]         i_pos_col,
    input  logic [4:0]         i_exit_row,
    input  logic [4:0]         i_exit_col,
    input  logic signed [15:0] i_cell_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_read_value,
    output logic [10:0]        o_path_length,
    output logic [14:0]        o_max_distance,
    output logic               o_status,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [5:0]         i_cfg_data
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [5:0] r_num_rows, r_num_cols;
    logic [5:0] used_rows, used_cols;
    logic       r_out_valid;
    t_result    r_out;
    t_item      item;
    t_result    res;
    logic       res_valid, res_ready;
    logic                  ram_we, ram_re;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    logic [LABEL_BITS-1:0] ram_wdata, ram_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows <= CFG_DIM_RESET;
            r_num_cols <= CFG_DIM_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_NUM_ROWS: r_num_rows <= i_cfg_data;
                CFG_NUM_COLS: r_num_cols <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign used_rows = ({3'b0, r_num_rows} > 9'(MAX_ROWS)) ? 6'(MAX_ROWS) : r_num_rows;
    assign used_cols = ({3'b0, r_num_cols} > 9'(MAX_COLS)) ? 6'(MAX_COLS) : r_num_cols;

    assign item = '{kind: t_kind'(i_kind), pos_row: i_pos_row, pos_col: i_pos_col,
                    exit_row: i_exit_row, exit_col: i_exit_col, cell_value: i_cell_value};

    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_read_value   = r_out.read_value;
    assign o_path_length  = r_out.path_length;
    assign o_max_distance = r_out.max_distance;
    assign o_status       = r_out.status;

    gdpt_seq #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_COLS  (MAX_COLS),
        .LABEL_BITS(LABEL_BITS),
        .AW        (AW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item_valid(i_in_valid),
        .o_item_ready(o_in_ready),
        .i_item      (item),
        .i_used_rows (used_rows),
        .i_used_cols (used_cols),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    gdpt_grid_ram #(
        .DEPTH(DEPTH),
        .AW   (AW),
        .DW   (LABEL_BITS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

endmodule
